>>> hdl/spms_pkg.sv
// shared types and constants of the stereo playback mode shaper
package spms_pkg;

    // fixed width of the codec and file words on the ports
    localparam int WORD_W = 16;

    // width of the configuration data bus (widest register)
    localparam int CFG_DATA_W = 17;

    // delay length after reset, in stereo frames
    localparam int RESET_DELAY_FRAMES = 44100;

    // configuration register indexes
    localparam logic [0:0] REG_PLAY_MODE    = 1'b0;
    localparam logic [0:0] REG_DELAY_LENGTH = 1'b1;

    // play modes
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_DOUBLE = 2'd1,
        MODE_HALF   = 2'd2,
        MODE_DELAY  = 2'd3
    } mode_t;

    // one resolved frame handed to the word sequencer
    typedef struct packed {
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
        logic              quad;
    } frame_t;

endpackage

>>> hdl/spms_ram.sv
// generic simple dual-port ram with registered read-first output
module spms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, returns the contents before a same-cycle write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/spms_word_seq.sv
// word sequencer: emits two or four codec words for each resolved frame
module spms_word_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          frame_valid,
    output logic                          frame_ready,
    input  spms_pkg::frame_t              frame,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [spms_pkg::WORD_W-1:0]   codec_word,
    output logic                          last_of_frame
);
    import spms_pkg::*;

    logic       busy_reg;
    logic       busy_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    frame_t     frame_reg;
    logic       out_accept;

    // word select: half speed repeats each word, other modes emit left, right
    always_comb
    begin
        if (frame_reg.quad)
        begin
            codec_word    = idx_reg[1] ? frame_reg.right : frame_reg.left;
            last_of_frame = (idx_reg == 2'd3);
        end
        else
        begin
            codec_word    = idx_reg[0] ? frame_reg.right : frame_reg.left;
            last_of_frame = (idx_reg == 2'd1);
        end
    end

    assign out_valid   = busy_reg;
    assign out_accept  = out_valid && out_ready;
    assign frame_ready = !busy_reg || (out_accept && last_of_frame);

    // sequencing control
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (frame_valid && frame_ready)
        begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end
        else if (out_accept)
        begin
            if (last_of_frame)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // frame payload
    always_ff @(posedge clk)
    begin
        if (frame_valid && frame_ready)
        begin
            frame_reg <= frame;
        end
    end

endmodule

>>> hdl/stereo_playback_mode_shaper_core.sv
// top level of the stereo playback mode shaper
// Takes one stereo frame per input transaction and emits codec words on the output
// channel: left, right in normal mode; left, left, right, right in half speed; the
// frame or two zero words on alternating frames in double speed; left and the right
// word delayed by delay_length frames in delay mode (zero until the line has filled
// once). Words come out one per cycle from the word sequencer while out_ready is high;
// a frame register in front of the sequencer lets the next frame be taken while words
// are still being emitted. A frame passes that register and the sequencer's own frame
// register before its first word. The delay line lives in a single ram that is read
// and written at the same slot in the accepting cycle, read-first, so back-to-back
// frames need no stall. The ram needs no clearing after reset. Configuration must be
// written only while idle; the user is bound by this and the block does not enforce it.
module stereo_playback_mode_shaper_core #(
    parameter int MAX_DELAY_FRAMES = 65536,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [spms_pkg::WORD_W-1:0]       left_word,
    input  logic [spms_pkg::WORD_W-1:0]       right_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [spms_pkg::WORD_W-1:0]       codec_word,
    output logic                              last_of_frame,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [0:0]                        cfg_index,
    input  logic [spms_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import spms_pkg::*;

    localparam int MASK_BITS = (SAMPLE_BITS < WORD_W) ? SAMPLE_BITS : WORD_W;
    localparam logic [WORD_W-1:0] WORD_MASK = WORD_W'((64'd1 << MASK_BITS) - 64'd1);
    localparam int PTR_BITS  = $clog2(MAX_DELAY_FRAMES);
    localparam int LEN_RAW   = $clog2(MAX_DELAY_FRAMES + 1);
    localparam int LEN_BITS  = (LEN_RAW > CFG_DATA_W) ? LEN_RAW : CFG_DATA_W;
    localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_DELAY_FRAMES);
    localparam logic [LEN_BITS-1:0] LEN_RESET =
        (RESET_DELAY_FRAMES > MAX_DELAY_FRAMES) ? LEN_MAX : LEN_BITS'(RESET_DELAY_FRAMES);

    typedef struct packed {
        frame_t frame;
        logic   use_delay;
        logic   filled;
    } stage_t;

    // configuration registers
    mode_t               mode_reg;
    mode_t               mode_next;
    logic [LEN_BITS-1:0] delay_len_reg;
    logic [LEN_BITS-1:0] delay_len_next;
    logic [LEN_BITS-1:0] cfg_len;

    // playback state
    logic                odd_frame_reg;
    logic                odd_frame_next;
    logic [PTR_BITS-1:0] delay_ptr_reg;
    logic [PTR_BITS-1:0] delay_ptr_next;
    logic                delay_filled_reg;
    logic                delay_filled_next;

    // frame stage between the ram read and the sequencer
    logic                s1_valid_reg;
    logic                s1_valid_next;
    stage_t              s1_reg;
    stage_t              s1_next;

    logic                in_accept;
    logic                ptr_wrap;
    logic                ram_en;
    logic [MASK_BITS-1:0] ram_rd_data;
    logic [WORD_W-1:0]   left_m;
    logic [WORD_W-1:0]   right_m;
    frame_t              seq_frame;
    logic                seq_ready;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;
    assign in_ready  = !s1_valid_reg || seq_ready;
    assign left_m    = left_word & WORD_MASK;
    assign right_m   = right_word & WORD_MASK;

    // clamp the written delay length to 1..MAX_DELAY_FRAMES
    always_comb
    begin
        cfg_len = LEN_BITS'(cfg_data);
        if (cfg_len == '0)
        begin
            cfg_len = LEN_BITS'(1);
        end
        else if (cfg_len > LEN_MAX)
        begin
            cfg_len = LEN_MAX;
        end
    end

    // configuration writes
    always_comb
    begin
        mode_next      = mode_reg;
        delay_len_next = delay_len_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PLAY_MODE:    mode_next = mode_t'(cfg_data[1:0]);
                REG_DELAY_LENGTH: delay_len_next = cfg_len;
                default:          mode_next = mode_reg;
            endcase
        end
    end

    assign ptr_wrap = (LEN_BITS'(delay_ptr_reg) + LEN_BITS'(1)) >= delay_len_reg;

    // per-frame state update and stage load
    always_comb
    begin
        odd_frame_next     = odd_frame_reg;
        delay_ptr_next     = delay_ptr_reg;
        delay_filled_next  = delay_filled_reg;
        ram_en             = 1'b0;
        s1_next            = s1_reg;
        s1_valid_next      = s1_valid_reg && !seq_ready;
        if (in_accept)
        begin
            s1_valid_next         = 1'b1;
            s1_next.frame.left    = left_m;
            s1_next.frame.right   = right_m;
            s1_next.frame.quad    = 1'b0;
            s1_next.use_delay     = 1'b0;
            s1_next.filled        = delay_filled_reg;
            case (mode_reg)
                MODE_NORMAL:
                begin
                    s1_next.frame.quad = 1'b0;
                end
                MODE_DOUBLE:
                begin
                    if (odd_frame_reg)
                    begin
                        s1_next.frame.left  = '0;
                        s1_next.frame.right = '0;
                    end
                    odd_frame_next = !odd_frame_reg;
                end
                MODE_HALF:
                begin
                    s1_next.frame.quad = 1'b1;
                end
                MODE_DELAY:
                begin
                    s1_next.use_delay = 1'b1;
                    ram_en            = 1'b1;
                    if (ptr_wrap)
                    begin
                        delay_ptr_next    = '0;
                        delay_filled_next = 1'b1;
                    end
                    else
                    begin
                        delay_ptr_next = delay_ptr_reg + PTR_BITS'(1);
                    end
                end
                default:
                begin
                    s1_next.frame.quad = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_NORMAL;
            delay_len_reg    <= LEN_RESET;
            odd_frame_reg    <= 1'b0;
            delay_ptr_reg    <= '0;
            delay_filled_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            mode_reg         <= mode_next;
            delay_len_reg    <= delay_len_next;
            odd_frame_reg    <= odd_frame_next;
            delay_ptr_reg    <= delay_ptr_next;
            delay_filled_reg <= delay_filled_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // delay line: old word read and new right word written at the same slot
    spms_ram #(
        .WIDTH (MASK_BITS),
        .DEPTH (MAX_DELAY_FRAMES)
    ) u_delay_ram (
        .clk     (clk),
        .we      (ram_en),
        .wr_addr (delay_ptr_reg),
        .wr_data (right_m[MASK_BITS-1:0]),
        .re      (ram_en),
        .rd_addr (delay_ptr_reg),
        .rd_data (ram_rd_data)
    );

    // resolve the delayed right word once the ram data is back
    always_comb
    begin
        seq_frame = s1_reg.frame;
        if (s1_reg.use_delay)
        begin
            seq_frame.right = s1_reg.filled ? WORD_W'(ram_rd_data) : '0;
        end
    end

    spms_word_seq u_word_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_valid   (s1_valid_reg),
        .frame_ready   (seq_ready),
        .frame         (seq_frame),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .codec_word    (codec_word),
        .last_of_frame (last_of_frame)
    );

`ifndef SYNTHESIS
    // the filled flag never clears once the line has wrapped
    a_filled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        delay_filled_reg |=> delay_filled_reg)
        else $error("delay filled flag cleared");

    // an accepted frame always lands in the frame stage
    a_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted frame lost before the sequencer");

    // a held frame stage blocks new input
    a_stage_block: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !seq_ready) |-> !in_ready)
        else $error("input taken while frame stage is stalled");

    // sequencer goes idle after the last word when nothing waits
    a_seq_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_of_frame && !s1_valid_reg) |=> !out_valid)
        else $error("word emitted with no frame pending");
`endif

endmodule

>>> dv/spms_checker.sv
// transaction monitor, frame predictor and scoreboard for the stereo playback mode shaper
module spms_checker #(
    parameter int MAX_DELAY_FRAMES = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [spms_pkg::WORD_W-1:0]     left_word,
    input  logic [spms_pkg::WORD_W-1:0]     right_word,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [spms_pkg::WORD_W-1:0]     codec_word,
    input  logic                            last_of_frame,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [0:0]                      cfg_index,
    input  logic [spms_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending_words
);
    import spms_pkg::*;

    // one expected codec word
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last_flag;
    } codec_beat_t;

    codec_beat_t expected_words[$];
    codec_beat_t head_beat;

    // shadow registers and shaper state
    mode_t                 play_mode_q;
    logic [CFG_DATA_W-1:0] delay_len_q;
    logic                  odd_frame_q;
    int unsigned           line_ptr_q;
    logic                  line_full_q;
    logic [WORD_W-1:0]     line_mem [MAX_DELAY_FRAMES];

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic push_word(input logic [WORD_W-1:0] word, input logic last_flag);
        codec_beat_t beat;
        beat.word      = word;
        beat.last_flag = last_flag;
        expected_words.push_back(beat);
    endtask

    // codec words caused by one stereo frame under the current mode
    task automatic shape_frame(input logic [WORD_W-1:0] left, input logic [WORD_W-1:0] right);
        int unsigned       span;
        int unsigned       slot;
        logic [WORD_W-1:0] delayed;
        case (play_mode_q)
            MODE_NORMAL:
            begin
                push_word(left, 1'b0);
                push_word(right, 1'b1);
            end
            MODE_DOUBLE:
            begin
                // every other frame is replaced by silence
                if (odd_frame_q)
                begin
                    push_word('0, 1'b0);
                    push_word('0, 1'b1);
                end
                else
                begin
                    push_word(left, 1'b0);
                    push_word(right, 1'b1);
                end
                odd_frame_q = ~odd_frame_q;
            end
            MODE_HALF:
            begin
                push_word(left, 1'b0);
                push_word(left, 1'b0);
                push_word(right, 1'b0);
                push_word(right, 1'b1);
            end
            default:
            begin
                // zero length acts as one frame, oversize saturates to the line size
                span = 32'(delay_len_q);
                if (span == 0)
                    span = 1;
                if (span > MAX_DELAY_FRAMES)
                    span = MAX_DELAY_FRAMES;
                slot = line_ptr_q;
                if (slot >= MAX_DELAY_FRAMES)
                    slot = 0;
                delayed = line_full_q ? line_mem[slot] : '0;
                line_mem[slot] = right;
                if (slot + 1 >= span)
                begin
                    line_ptr_q  = 0;
                    line_full_q = 1'b1;
                end
                else
                begin
                    line_ptr_q = slot + 1;
                end
                push_word(left, 1'b0);
                push_word(delayed, 1'b1);
            end
        endcase
    endtask

    // watch all three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_mode_q  = MODE_NORMAL;
            delay_len_q  = CFG_DATA_W'(RESET_DELAY_FRAMES);
            odd_frame_q  = 1'b0;
            line_ptr_q   = 0;
            line_full_q  = 1'b0;
            fail_count   = 0;
            expected_words.delete();
            pending_words <= 0;
        end
        else
        begin
            // register write transaction
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PLAY_MODE)
                    play_mode_q = mode_t'(cfg_data[1:0]);
                else
                    delay_len_q = cfg_data;
            end

            // codec word transaction
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected codec word %h last %b",
                                              codec_word, last_of_frame));
                end
                else
                begin
                    head_beat = expected_words.pop_front();
                    if (codec_word !== head_beat.word)
                        report_mismatch($sformatf("codec_word %h, expected %h",
                                                  codec_word, head_beat.word));
                    if (last_of_frame !== head_beat.last_flag)
                        report_mismatch($sformatf("last_of_frame %b, expected %b (word %h)",
                                                  last_of_frame, head_beat.last_flag,
                                                  head_beat.word));
                end
            end

            // stereo frame transaction
            if (in_valid && in_ready)
                shape_frame(left_word, right_word);

            pending_words <= expected_words.size();
        end
    end

endmodule

>>> dv/tb_stereo_playback_mode_shaper_core.sv
// testbench top for the stereo playback mode shaper: clock, reset, stimulus and verdict
module tb_stereo_playback_mode_shaper_core;
    import spms_pkg::*;

    localparam int RUN_LIMIT             = 400000;
    localparam int TARGET_FRAMES         = 410;
    localparam int DIRECTED_DELAY_FRAMES = 7;
    localparam int PREFILL_FRAMES        = 80;
    // slots written before the delay line first wraps; later lengths stay within them
    localparam int FILLED_SLOTS          = DIRECTED_DELAY_FRAMES + PREFILL_FRAMES + 1;
    localparam int HOLD_OFF_CYCLES       = 150;
    localparam int CORNER_COUNT          = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [WORD_W-1:0]     left_word;
    logic [WORD_W-1:0]     right_word;
    logic                  out_valid;
    logic                  out_ready;
    logic [WORD_W-1:0]     codec_word;
    logic                  last_of_frame;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [0:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending_words;
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_cycles;
    int frames_sent;

    // left/right corner pairs
    logic [2*WORD_W-1:0] corner_frames [CORNER_COUNT] = '{
        32'h0000_FFFF, 32'hFFFF_0000, 32'hAAAA_5555, 32'h5555_AAAA,
        32'h0001_8000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000
    };

    stereo_playback_mode_shaper_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .left_word     (left_word),
        .right_word    (right_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .codec_word    (codec_word),
        .last_of_frame (last_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    spms_checker #(
        .MAX_DELAY_FRAMES (65536)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .left_word     (left_word),
        .right_word    (right_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .codec_word    (codec_word),
        .last_of_frame (last_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // codec side: random stalls, plus a long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // wait until every expected codec word has come
    task automatic wait_idle();
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
    endtask

    // mode write, optionally followed by a delay length write
    task automatic write_regs(input mode_t mode, input logic [CFG_DATA_W-1:0] span,
                              input bit with_span);
        logic [CFG_DATA_W-1:0] mode_word;
        wait_idle();
        // unused upper bits carry noise
        mode_word      = CFG_DATA_W'($urandom());
        mode_word[1:0] = mode;
        cfg_valid <= 1'b1;
        cfg_index <= REG_PLAY_MODE;
        cfg_data  <= mode_word;
        do @(posedge clk); while (!cfg_ready);
        if (with_span)
        begin
            cfg_index <= REG_DELAY_LENGTH;
            cfg_data  <= span;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // one frame transaction; valid stays high afterwards for back-to-back frames
    task automatic send_frame(input logic [WORD_W-1:0] left, input logic [WORD_W-1:0] right);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid   <= 1'b1;
        left_word  <= left;
        right_word <= right;
        do @(posedge clk); while (!in_ready);
        frames_sent++;
    endtask

    task automatic play_corners(input int first, input int count);
        logic [2*WORD_W-1:0] pair;
        for (int k = 0; k < count; k++)
        begin
            pair = corner_frames[(first + k) % CORNER_COUNT];
            send_frame(pair[2*WORD_W-1:WORD_W], pair[WORD_W-1:0]);
        end
        in_valid <= 1'b0;
    endtask

    // random frames, with silent frames and corner values mixed in
    task automatic play_burst(input int count);
        logic [2*WORD_W-1:0] pair;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(9))
                0:       pair = '0;
                1:       pair = corner_frames[$urandom_range(CORNER_COUNT-1)];
                default: pair = {WORD_W'($urandom()), WORD_W'($urandom())};
            endcase
            send_frame(pair[2*WORD_W-1:WORD_W], pair[WORD_W-1:0]);
        end
        in_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        mode_t                 mode;
        logic [CFG_DATA_W-1:0] span;
        int                    phase;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        left_word      <= '0;
        right_word     <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_PLAY_MODE;
        cfg_data       <= '0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        rx_hold_cycles = 0;
        frames_sent    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // normal mode straight out of reset
        play_corners(0, 4);
        // double speed: even, odd, even frame
        write_regs(MODE_DOUBLE, '0, 1'b0);
        play_corners(4, 3);
        write_regs(MODE_HALF, '0, 1'b0);
        play_corners(0, 2);
        // parity must survive a detour through normal mode
        write_regs(MODE_NORMAL, '0, 1'b0);
        play_corners(2, 1);
        write_regs(MODE_DOUBLE, '0, 1'b0);
        play_corners(3, 1);
        // delay with the reset length, then oversize and full-size lengths
        write_regs(MODE_DELAY, '0, 1'b0);
        play_corners(4, 3);
        write_regs(MODE_DELAY, '1, 1'b1);
        play_corners(0, 2);
        write_regs(MODE_DELAY, CFG_DATA_W'(65536), 1'b1);
        play_corners(2, 2);
        // delay state must be left alone outside delay mode
        write_regs(MODE_NORMAL, '0, 1'b0);
        play_corners(6, 1);

        // fill the line part way without wrapping
        write_regs(MODE_DELAY, CFG_DATA_W'(65536), 1'b1);
        play_burst(PREFILL_FRAMES);

        // length lowered below the pointer: wraps at once and marks the line full
        tx_idle_pct = 77;
        write_regs(MODE_DELAY, CFG_DATA_W'(40), 1'b1);
        play_burst(40);

        // codec holds off while frames keep coming, so the input backs up
        tx_idle_pct = 0;
        write_regs(MODE_HALF, '0, 1'b0);
        rx_hold_cycles = HOLD_OFF_CYCLES;
        play_burst(24);

        // random phases across all idle patterns
        phase = 0;
        while (frames_sent < TARGET_FRAMES)
        begin
            case (phase % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 77;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 77;
                end
                default:
                begin
                    tx_idle_pct  = 38;
                    rx_stall_pct = 38;
                end
            endcase
            mode = mode_t'($urandom_range(3));
            case ($urandom_range(4))
                0:       span = '0;
                1:       span = CFG_DATA_W'(1);
                2:       span = CFG_DATA_W'(FILLED_SLOTS);
                default: span = CFG_DATA_W'($urandom_range(FILLED_SLOTS, 1));
            endcase
            write_regs(mode, span, 1'b1);
            play_burst($urandom_range(40, 16));
            phase++;
        end

        // drain, then allow for stray words
        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
hdl/spms_pkg.sv
hdl/spms_ram.sv
hdl/spms_word_seq.sv
hdl/stereo_playback_mode_shaper_core.sv
dv/spms_checker.sv
dv/tb_stereo_playback_mode_shaper_core.sv
